/* sv/gmap_pkg.sv */
package gmap_pkg;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_CANGO  = 3'd1;
    localparam logic [2:0] OP_FIND   = 3'd2;
    localparam logic [2:0] OP_MOVE   = 3'd3;
    localparam logic [2:0] OP_LEAVE  = 3'd4;
    localparam logic [2:0] OP_PATH   = 3'd5;
    localparam logic [2:0] OP_RDPATH = 3'd6;

    localparam logic [1:0] CFG_MIN_X = 2'd0;
    localparam logic [1:0] CFG_MAX_X = 2'd1;
    localparam logic [1:0] CFG_MIN_Y = 2'd2;
    localparam logic [1:0] CFG_MAX_Y = 2'd3;

    localparam int HEUR_W    = 10;
    localparam int STEP_COST = 10;

    typedef logic [4:0] t_uop;

    localparam t_uop U_NOP        = 5'd0;
    localparam t_uop U_LATCH      = 5'd1;
    localparam t_uop U_CLR_MAP    = 5'd2;
    localparam t_uop U_RD_T       = 5'd3;
    localparam t_uop U_RD_F       = 5'd4;
    localparam t_uop U_LOAD       = 5'd5;
    localparam t_uop U_CANGO      = 5'd6;
    localparam t_uop U_FIND       = 5'd7;
    localparam t_uop U_MV_CHK     = 5'd8;
    localparam t_uop U_MV_CLR     = 5'd9;
    localparam t_uop U_MV_WR      = 5'd10;
    localparam t_uop U_LEAVE      = 5'd11;
    localparam t_uop U_S_CLR      = 5'd12;
    localparam t_uop U_SEED       = 5'd13;
    localparam t_uop U_SCAN_START = 5'd14;
    localparam t_uop U_SCAN       = 5'd15;
    localparam t_uop U_CLOSE      = 5'd16;
    localparam t_uop U_NB_RD      = 5'd17;
    localparam t_uop U_NB_EV      = 5'd18;
    localparam t_uop U_P_INIT     = 5'd19;
    localparam t_uop U_P_STEP     = 5'd20;
    localparam t_uop U_P_BACK     = 5'd21;
    localparam t_uop U_P_DONE     = 5'd22;
    localparam t_uop U_P_FAIL     = 5'd23;
    localparam t_uop U_RD_PATH    = 5'd24;
    localparam t_uop U_RD_OUT     = 5'd25;
    localparam t_uop U_PUSH       = 5'd26;

    typedef struct packed {
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       tin;
        logic       fin;
        logic       cnt_last;
        logic       dir_last;
        logic       best_v;
        logic       is_goal;
        logic       at_start;
    } t_stat;

    function automatic logic signed [16:0] row_step(input logic [1:0] d);
        logic signed [16:0] s;
        unique case (d)
            2'd0: s = 17'sd1;
            2'd1: s = -17'sd1;
            default: s = 17'sd0;
        endcase
        return s;
    endfunction

    function automatic logic signed [16:0] col_step(input logic [1:0] d);
        logic signed [16:0] s;
        unique case (d)
            2'd2: s = -17'sd1;
            2'd3: s = 17'sd1;
            default: s = 17'sd0;
        endcase
        return s;
    endfunction

endpackage

/* sv/gmap_in_if.sv */
interface gmap_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [15:0]        obj_id;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic               check_objects;
    logic               blocked;
    logic [11:0]        path_index;

    modport source (
        output valid, op, obj_id, from_x, from_y, to_x, to_y, check_objects, blocked,
               path_index,
        input  ready
    );
    modport sink (
        input  valid, op, obj_id, from_x, from_y, to_x, to_y, check_objects, blocked,
               path_index,
        output ready
    );
endinterface

/* sv/gmap_out_if.sv */
interface gmap_out_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [15:0]        occupant;
    logic [12:0]        path_length;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;

    modport source (
        output valid, ok, occupant, path_length, cell_x, cell_y,
        input  ready
    );
    modport sink (
        input  valid, ok, occupant, path_length, cell_x, cell_y,
        output ready
    );
endinterface

/* sv/grid_map_astar_pathfinder_top.sv */
// Channel   Direction  Payload
// i_req     in         op, obj_id, from_x/y, to_x/y, check_objects, blocked, path_index
// o_rsp     out        ok, occupant, path_length, cell_x, cell_y
// i_cfg_*   in         write enable, register index, 16-bit data
//
// A path search clears the search memory, then for each expanded cell scans the whole
// search memory through its one read port, then writes the path cells back from the goal.
// The search memory has 2**(clog2(GRID_H)+clog2(GRID_W)) entries.
// After reset the map memories are cleared before the first transaction.
// A waiting result holds in the output register while the next transaction is processed.
module grid_map_astar_pathfinder_top #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gmap_in_if.sink     i_req,
    gmap_out_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    gmap_pkg::t_cmd  cmd;
    gmap_pkg::t_stat stat;

    gmap_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    gmap_datapath #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_req.op),
        .i_obj_id        (i_req.obj_id),
        .i_from_x        (i_req.from_x),
        .i_from_y        (i_req.from_y),
        .i_to_x          (i_req.to_x),
        .i_to_y          (i_req.to_y),
        .i_check_objects (i_req.check_objects),
        .i_blocked       (i_req.blocked),
        .i_path_index    (i_req.path_index),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_ok            (o_rsp.ok),
        .o_occupant      (o_rsp.occupant),
        .o_path_length   (o_rsp.path_length),
        .o_cell_x        (o_rsp.cell_x),
        .o_cell_y        (o_rsp.cell_y)
    );

endmodule

/* sv/gmap_datapath.sv */
module gmap_datapath #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [15:0]               i_cfg_data,
    input  logic [2:0]                i_op,
    input  logic [15:0]               i_obj_id,
    input  logic signed [15:0]        i_from_x,
    input  logic signed [15:0]        i_from_y,
    input  logic signed [15:0]        i_to_x,
    input  logic signed [15:0]        i_to_y,
    input  logic                      i_check_objects,
    input  logic                      i_blocked,
    input  logic [11:0]               i_path_index,
    input  gmap_pkg::t_cmd            i_cmd,
    output gmap_pkg::t_stat           o_stat,
    output logic                      o_ok,
    output logic [15:0]               o_occupant,
    output logic [12:0]               o_path_length,
    output logic signed [15:0]        o_cell_x,
    output logic signed [15:0]        o_cell_y
);

    localparam int RW    = $clog2(GRID_H);
    localparam int CW    = $clog2(GRID_W);
    localparam int AW    = RW + CW;
    localparam int MD    = 1 << AW;
    localparam int CELLS = GRID_W * GRID_H;
    localparam int PIW   = $clog2(CELLS);
    localparam int PCW   = $clog2(CELLS + 1);
    localparam int SW    = $clog2(10 * (CELLS + GRID_W + GRID_H) + 2);
    localparam int XW    = SW + 3;
    localparam logic [SW-1:0] NONE = {SW{1'b1}};
    localparam logic signed [16:0] GW17 = 17'(GRID_W);
    localparam logic signed [16:0] GH17 = 17'(GRID_H);

    logic              mem_col  [MD];
    logic [15:0]       mem_occ  [MD];
    logic [XW-1:0]     mem_srch [MD];
    logic [AW-1:0]     mem_path [CELLS];

    logic signed [15:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [2:0]         r_op;
    logic [15:0]        r_obj;
    logic               r_chk, r_blk;
    logic [11:0]        r_pidx;
    logic               r_tin, r_fin;
    logic [AW-1:0]      r_taddr, r_faddr;
    logic signed [16:0] r_spanx, r_spany;
    logic [AW-1:0]      r_cnt;
    logic               r_col_rd;
    logic [15:0]        r_occ_rd;
    logic               r_mv;
    logic [XW-1:0]      r_srd;
    logic               r_sc_pend;
    logic [AW-1:0]      r_sc_addr;
    logic               r_best_v;
    logic [AW-1:0]      r_best_addr;
    logic [1:0]         r_best_par;
    logic [SW-1:0]      r_best_score;
    logic [AW-1:0]      r_cur;
    logic [SW-1:0]      r_g;
    logic               r_nb_in, r_nb_goal;
    logic [AW-1:0]      r_nb_addr;
    logic [SW-1:0]      r_nf;
    logic [AW-1:0]      r_walk;
    logic [PCW-1:0]     r_k, r_pcount;
    logic [AW-1:0]      r_prd;
    logic               r_rd_in;
    logic               r_ok;
    logic [15:0]        r_occ;
    logic [12:0]        r_plen;
    logic signed [15:0] r_cx, r_cy;
    logic               r_o_ok;
    logic [15:0]        r_o_occ;
    logic [12:0]        r_o_plen;
    logic signed [15:0] r_o_cx, r_o_cy;

    function automatic logic [SW-1:0] heur(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [RW-1:0] ra, rb, dr;
        logic [CW-1:0] ca, cb, dc;
        ra = a[AW-1:CW];
        rb = b[AW-1:CW];
        ca = a[CW-1:0];
        cb = b[CW-1:0];
        dr = (ra > rb) ? ra - rb : rb - ra;
        dc = (ca > cb) ? ca - cb : cb - ca;
        return (SW'(dr) + SW'(dc)) * SW'(gmap_pkg::HEUR_W);
    endfunction

    function automatic logic in_map(input logic signed [16:0] r, input logic signed [16:0] c,
                                    input logic signed [16:0] spx,
                                    input logic signed [16:0] spy);
        return (r >= 0) && (c >= 0) && (r <= spy) && (c <= spx) && (r < GH17) && (c < GW17);
    endfunction

    logic signed [16:0] tc, tr, fc, fr, spanx, spany;
    logic signed [16:0] nr17, nc17, br17, bc17;
    logic [AW-1:0]      nb_addr, back_addr;
    logic               nb_in;
    logic [SW-1:0]      nf;
    logic [1:0]         dir;
    logic               nb_take;
    logic [PCW+11:0]    pdiff;

    assign spanx = $signed({r_max_x[15], r_max_x}) - $signed({r_min_x[15], r_min_x});
    assign spany = $signed({r_max_y[15], r_max_y}) - $signed({r_min_y[15], r_min_y});
    assign tc = $signed({i_to_x[15], i_to_x}) - $signed({r_min_x[15], r_min_x});
    assign tr = $signed({r_max_y[15], r_max_y}) - $signed({i_to_y[15], i_to_y});
    assign fc = $signed({i_from_x[15], i_from_x}) - $signed({r_min_x[15], r_min_x});
    assign fr = $signed({r_max_y[15], r_max_y}) - $signed({i_from_y[15], i_from_y});

    assign dir  = r_cnt[1:0];
    assign nr17 = $signed(17'(r_cur[AW-1:CW])) + gmap_pkg::row_step(dir);
    assign nc17 = $signed(17'(r_cur[CW-1:0])) + gmap_pkg::col_step(dir);
    assign nb_in = (nr17 >= 0) && (nc17 >= 0) && (nr17 < GH17) && (nc17 < GW17)
                   && (nr17 <= r_spany) && (nc17 <= r_spanx);
    assign nb_addr = {nr17[RW-1:0], nc17[CW-1:0]};
    assign nf = r_g + SW'(gmap_pkg::STEP_COST) + heur(nb_addr, r_taddr);

    assign br17 = $signed(17'(r_walk[AW-1:CW])) - gmap_pkg::row_step(r_srd[SW+1:SW]);
    assign bc17 = $signed(17'(r_walk[CW-1:0])) - gmap_pkg::col_step(r_srd[SW+1:SW]);
    assign back_addr = {br17[RW-1:0], bc17[CW-1:0]};

    assign nb_take = r_nb_in
                     && (r_nb_goal || (!r_col_rd && (!r_chk || r_occ_rd == 16'd0)))
                     && !r_srd[SW+2] && (r_nf < r_srd[SW-1:0]);

    assign pdiff = (PCW + 12)'(r_pcount) - (PCW + 12)'(1) - (PCW + 12)'(r_pidx);

    // Map memories: collision bits and occupant ids share one read address.
    logic          map_re, col_we, occ_we;
    logic [AW-1:0] map_ra, col_wa, occ_wa;
    logic          col_wd;
    logic [15:0]   occ_wd;

    always_comb begin
        map_re = 1'b0;
        map_ra = r_taddr;
        col_we = 1'b0;
        col_wa = r_taddr;
        col_wd = r_blk;
        occ_we = 1'b0;
        occ_wa = r_taddr;
        occ_wd = 16'd0;
        case (i_cmd.uop)
            gmap_pkg::U_RD_T: begin
                map_re = 1'b1;
            end
            gmap_pkg::U_RD_F, gmap_pkg::U_MV_CHK: begin
                map_re = 1'b1;
                map_ra = r_faddr;
            end
            gmap_pkg::U_NB_RD: begin
                map_re = 1'b1;
                map_ra = nb_addr;
            end
            gmap_pkg::U_CLR_MAP: begin
                col_we = 1'b1;
                col_wa = r_cnt;
                col_wd = 1'b0;
                occ_we = 1'b1;
                occ_wa = r_cnt;
            end
            gmap_pkg::U_LOAD: begin
                col_we = r_tin;
            end
            gmap_pkg::U_MV_CLR: begin
                occ_we = r_mv && r_fin && (r_occ_rd == r_obj);
                occ_wa = r_faddr;
            end
            gmap_pkg::U_MV_WR: begin
                occ_we = r_mv;
                occ_wd = r_obj;
            end
            gmap_pkg::U_LEAVE: begin
                occ_we = (r_obj != 16'd0) && r_fin && (r_occ_rd == r_obj);
                occ_wa = r_faddr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            mem_col[col_wa] <= col_wd;
        end
        if (occ_we) begin
            mem_occ[occ_wa] <= occ_wd;
        end
        if (map_re) begin
            r_col_rd <= mem_col[map_ra];
            r_occ_rd <= mem_occ[map_ra];
        end
    end

    // Search memory: closed flag, parent direction and F score per cell.
    logic          srch_re, srch_we;
    logic [AW-1:0] srch_ra, srch_wa;
    logic [XW-1:0] srch_wd;

    always_comb begin
        srch_re = 1'b0;
        srch_ra = r_cnt;
        srch_we = 1'b0;
        srch_wa = r_cnt;
        srch_wd = {1'b0, 2'b00, NONE};
        case (i_cmd.uop)
            gmap_pkg::U_S_CLR: begin
                srch_we = 1'b1;
            end
            gmap_pkg::U_SEED: begin
                srch_we = 1'b1;
                srch_wa = r_faddr;
                srch_wd = {1'b0, 2'b00, heur(r_faddr, r_taddr)};
            end
            gmap_pkg::U_SCAN: begin
                srch_re = 1'b1;
            end
            gmap_pkg::U_CLOSE: begin
                srch_we = 1'b1;
                srch_wa = r_best_addr;
                srch_wd = {1'b1, r_best_par, r_best_score};
            end
            gmap_pkg::U_NB_RD: begin
                srch_re = 1'b1;
                srch_ra = nb_addr;
            end
            gmap_pkg::U_NB_EV: begin
                srch_we = nb_take;
                srch_wa = r_nb_addr;
                srch_wd = {1'b0, dir, r_nf};
            end
            gmap_pkg::U_P_STEP: begin
                srch_re = 1'b1;
                srch_ra = r_walk;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (srch_we) begin
            mem_srch[srch_wa] <= srch_wd;
        end
        if (srch_re) begin
            r_srd <= mem_srch[srch_ra];
        end
    end

    // Path memory holds the cells from the goal back to the start.
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == gmap_pkg::U_P_STEP) begin
            mem_path[PIW'(r_k)] <= r_walk;
        end
        if (i_cmd.uop == gmap_pkg::U_RD_PATH) begin
            r_prd <= mem_path[PIW'(pdiff)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x   <= 16'sd0;
            r_max_x   <= 16'sd63;
            r_min_y   <= 16'sd0;
            r_max_y   <= 16'sd63;
            r_cnt     <= '0;
            r_sc_pend <= 1'b0;
            r_best_v  <= 1'b0;
            r_pcount  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gmap_pkg::CFG_MIN_X: r_min_x <= i_cfg_data;
                    gmap_pkg::CFG_MAX_X: r_max_x <= i_cfg_data;
                    gmap_pkg::CFG_MIN_Y: r_min_y <= i_cfg_data;
                    gmap_pkg::CFG_MAX_Y: r_max_y <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_sc_pend <= (i_cmd.uop == gmap_pkg::U_SCAN);
            case (i_cmd.uop)
                gmap_pkg::U_LATCH, gmap_pkg::U_SCAN_START, gmap_pkg::U_CLOSE: begin
                    r_cnt <= '0;
                end
                gmap_pkg::U_CLR_MAP, gmap_pkg::U_S_CLR, gmap_pkg::U_SCAN,
                gmap_pkg::U_NB_EV: begin
                    r_cnt <= r_cnt + AW'(1);
                end
                gmap_pkg::U_P_DONE: begin
                    r_pcount <= r_k;
                end
                gmap_pkg::U_P_FAIL: begin
                    r_pcount <= '0;
                end
                default: begin
                end
            endcase
            if (i_cmd.uop == gmap_pkg::U_SCAN_START) begin
                r_best_v <= 1'b0;
            end
            if (r_sc_pend && !r_srd[SW+2] && (r_srd[SW-1:0] != NONE)
                    && (!r_best_v || r_srd[SW-1:0] < r_best_score)) begin
                r_best_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sc_pend && !r_srd[SW+2] && (r_srd[SW-1:0] != NONE)
                && (!r_best_v || r_srd[SW-1:0] < r_best_score)) begin
            r_best_addr  <= r_sc_addr;
            r_best_par   <= r_srd[SW+1:SW];
            r_best_score <= r_srd[SW-1:0];
        end
        r_sc_addr <= r_cnt;
        case (i_cmd.uop)
            gmap_pkg::U_LATCH: begin
                r_op    <= i_op;
                r_obj   <= i_obj_id;
                r_chk   <= i_check_objects;
                r_blk   <= i_blocked;
                r_pidx  <= i_path_index;
                r_tin   <= in_map(tr, tc, spanx, spany);
                r_fin   <= in_map(fr, fc, spanx, spany);
                r_taddr <= {tr[RW-1:0], tc[CW-1:0]};
                r_faddr <= {fr[RW-1:0], fc[CW-1:0]};
                r_spanx <= spanx;
                r_spany <= spany;
                r_ok    <= 1'b0;
                r_occ   <= 16'd0;
                r_plen  <= 13'd0;
                r_cx    <= 16'sd0;
                r_cy    <= 16'sd0;
            end
            gmap_pkg::U_LOAD: begin
                r_ok <= r_tin;
            end
            gmap_pkg::U_CANGO: begin
                r_ok <= r_tin && !r_col_rd && (!r_chk || r_occ_rd == 16'd0);
            end
            gmap_pkg::U_FIND: begin
                r_ok  <= r_tin;
                r_occ <= r_tin ? r_occ_rd : 16'd0;
            end
            gmap_pkg::U_MV_CHK: begin
                r_mv <= (r_obj != 16'd0) && r_tin && !r_col_rd && (r_occ_rd == 16'd0);
            end
            gmap_pkg::U_MV_WR: begin
                r_ok <= r_mv;
            end
            gmap_pkg::U_LEAVE: begin
                r_ok <= (r_obj != 16'd0) && r_fin;
            end
            gmap_pkg::U_CLOSE: begin
                r_cur <= r_best_addr;
                r_g   <= r_best_score - heur(r_best_addr, r_taddr);
            end
            gmap_pkg::U_NB_RD: begin
                r_nb_in   <= nb_in;
                r_nb_goal <= (nb_addr == r_taddr);
                r_nb_addr <= nb_addr;
                r_nf      <= nf;
            end
            gmap_pkg::U_P_INIT: begin
                r_walk <= r_taddr;
                r_k    <= '0;
            end
            gmap_pkg::U_P_STEP: begin
                r_k <= r_k + PCW'(1);
            end
            gmap_pkg::U_P_BACK: begin
                r_walk <= back_addr;
            end
            gmap_pkg::U_P_DONE: begin
                r_ok   <= 1'b1;
                r_plen <= 13'(r_k);
            end
            gmap_pkg::U_P_FAIL: begin
                r_ok   <= 1'b0;
                r_plen <= 13'd0;
            end
            gmap_pkg::U_RD_PATH: begin
                r_rd_in <= (PCW + 12)'(r_pidx) < (PCW + 12)'(r_pcount);
            end
            gmap_pkg::U_RD_OUT: begin
                r_plen <= 13'(r_pcount);
                r_ok   <= r_rd_in;
                if (r_rd_in) begin
                    r_cx <= r_min_x + 16'(r_prd[CW-1:0]);
                    r_cy <= r_max_y - 16'(r_prd[AW-1:CW]);
                end
            end
            gmap_pkg::U_PUSH: begin
                r_o_ok   <= r_ok;
                r_o_occ  <= r_occ;
                r_o_plen <= r_plen;
                r_o_cx   <= r_cx;
                r_o_cy   <= r_cy;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.op       = r_op;
    assign o_stat.tin      = r_tin;
    assign o_stat.fin      = r_fin;
    assign o_stat.cnt_last = &r_cnt;
    assign o_stat.dir_last = (r_cnt[1:0] == 2'b11);
    assign o_stat.best_v   = r_best_v;
    assign o_stat.is_goal  = (r_best_addr == r_taddr);
    assign o_stat.at_start = (r_walk == r_faddr);

    assign o_ok          = r_o_ok;
    assign o_occupant    = r_o_occ;
    assign o_path_length = r_o_plen;
    assign o_cell_x      = r_o_cx;
    assign o_cell_y      = r_o_cy;

endmodule

/* sv/gmap_ctrl.sv */
module gmap_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  gmap_pkg::t_stat i_stat,
    output gmap_pkg::t_cmd  o_cmd
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_CANGO = 5'd3;
    localparam logic [4:0] S_FIND  = 5'd4;
    localparam logic [4:0] S_MV1   = 5'd5;
    localparam logic [4:0] S_MV2   = 5'd6;
    localparam logic [4:0] S_MV3   = 5'd7;
    localparam logic [4:0] S_LV    = 5'd8;
    localparam logic [4:0] S_SCLR  = 5'd9;
    localparam logic [4:0] S_SEED  = 5'd10;
    localparam logic [4:0] S_SCAN0 = 5'd11;
    localparam logic [4:0] S_SCAN  = 5'd12;
    localparam logic [4:0] S_SCANE = 5'd13;
    localparam logic [4:0] S_SEL   = 5'd14;
    localparam logic [4:0] S_NBR   = 5'd15;
    localparam logic [4:0] S_NBE   = 5'd16;
    localparam logic [4:0] S_PINIT = 5'd17;
    localparam logic [4:0] S_PSTEP = 5'd18;
    localparam logic [4:0] S_PBACK = 5'd19;
    localparam logic [4:0] S_PDONE = 5'd20;
    localparam logic [4:0] S_RDP   = 5'd21;
    localparam logic [4:0] S_PUSH  = 5'd22;

    logic [4:0] r_state, n_state;
    logic       r_out_v, n_out_v;

    always_comb begin
        n_state   = r_state;
        o_cmd.uop = gmap_pkg::U_NOP;
        n_out_v   = r_out_v && !i_out_ready;
        unique case (r_state)
            S_CLR: begin
                o_cmd.uop = gmap_pkg::U_CLR_MAP;
                if (i_stat.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.uop = gmap_pkg::U_LATCH;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.op)
                    gmap_pkg::OP_LOAD: begin
                        o_cmd.uop = gmap_pkg::U_LOAD;
                        n_state   = S_PUSH;
                    end
                    gmap_pkg::OP_CANGO: begin
                        o_cmd.uop = gmap_pkg::U_RD_T;
                        n_state   = S_CANGO;
                    end
                    gmap_pkg::OP_FIND: begin
                        o_cmd.uop = gmap_pkg::U_RD_T;
                        n_state   = S_FIND;
                    end
                    gmap_pkg::OP_MOVE: begin
                        o_cmd.uop = gmap_pkg::U_RD_T;
                        n_state   = S_MV1;
                    end
                    gmap_pkg::OP_LEAVE: begin
                        o_cmd.uop = gmap_pkg::U_RD_F;
                        n_state   = S_LV;
                    end
                    gmap_pkg::OP_PATH: begin
                        if (i_stat.tin && i_stat.fin) begin
                            n_state = S_SCLR;
                        end else begin
                            o_cmd.uop = gmap_pkg::U_P_FAIL;
                            n_state   = S_PUSH;
                        end
                    end
                    gmap_pkg::OP_RDPATH: begin
                        o_cmd.uop = gmap_pkg::U_RD_PATH;
                        n_state   = S_RDP;
                    end
                    default: begin
                        n_state = S_PUSH;
                    end
                endcase
            end
            S_CANGO: begin
                o_cmd.uop = gmap_pkg::U_CANGO;
                n_state   = S_PUSH;
            end
            S_FIND: begin
                o_cmd.uop = gmap_pkg::U_FIND;
                n_state   = S_PUSH;
            end
            S_MV1: begin
                o_cmd.uop = gmap_pkg::U_MV_CHK;
                n_state   = S_MV2;
            end
            S_MV2: begin
                o_cmd.uop = gmap_pkg::U_MV_CLR;
                n_state   = S_MV3;
            end
            S_MV3: begin
                o_cmd.uop = gmap_pkg::U_MV_WR;
                n_state   = S_PUSH;
            end
            S_LV: begin
                o_cmd.uop = gmap_pkg::U_LEAVE;
                n_state   = S_PUSH;
            end
            S_SCLR: begin
                o_cmd.uop = gmap_pkg::U_S_CLR;
                if (i_stat.cnt_last) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                o_cmd.uop = gmap_pkg::U_SEED;
                n_state   = S_SCAN0;
            end
            S_SCAN0: begin
                o_cmd.uop = gmap_pkg::U_SCAN_START;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.uop = gmap_pkg::U_SCAN;
                if (i_stat.cnt_last) begin
                    n_state = S_SCANE;
                end
            end
            S_SCANE: begin
                n_state = S_SEL;
            end
            S_SEL: begin
                if (!i_stat.best_v) begin
                    o_cmd.uop = gmap_pkg::U_P_FAIL;
                    n_state   = S_PUSH;
                end else begin
                    o_cmd.uop = gmap_pkg::U_CLOSE;
                    n_state   = i_stat.is_goal ? S_PINIT : S_NBR;
                end
            end
            S_NBR: begin
                o_cmd.uop = gmap_pkg::U_NB_RD;
                n_state   = S_NBE;
            end
            S_NBE: begin
                o_cmd.uop = gmap_pkg::U_NB_EV;
                n_state   = i_stat.dir_last ? S_SCAN0 : S_NBR;
            end
            S_PINIT: begin
                o_cmd.uop = gmap_pkg::U_P_INIT;
                n_state   = S_PSTEP;
            end
            S_PSTEP: begin
                o_cmd.uop = gmap_pkg::U_P_STEP;
                n_state   = i_stat.at_start ? S_PDONE : S_PBACK;
            end
            S_PBACK: begin
                o_cmd.uop = gmap_pkg::U_P_BACK;
                n_state   = S_PSTEP;
            end
            S_PDONE: begin
                o_cmd.uop = gmap_pkg::U_P_DONE;
                n_state   = S_PUSH;
            end
            S_RDP: begin
                o_cmd.uop = gmap_pkg::U_RD_OUT;
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_v || i_out_ready) begin
                    o_cmd.uop = gmap_pkg::U_PUSH;
                    n_out_v   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;

endmodule

/* tb/tb_grid_map_astar_pathfinder_top.sv */
module tb_grid_map_astar_pathfinder_top;

    localparam int GW = 64;
    localparam int GH = 64;
    localparam int NCELL = GW * GH;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] obj_id;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] tx;
        logic [15:0] ty;
        logic        chk;
        logic        blk;
        logic [11:0] pidx;
    } t_req;

    typedef struct {
        logic        ok;
        logic [15:0] occ;
        logic [12:0] plen;
        logic [15:0] cx;
        logic [15:0] cy;
    } t_rsp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    gmap_in_if  req_if();
    gmap_out_if rsp_if();

    grid_map_astar_pathfinder_top #(.GRID_W(GW), .GRID_H(GH)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    int     mnx, mxx, mny, mxy;
    bit     coll_map [NCELL];
    logic [15:0] occ_map [NCELL];
    int unsigned open_f [NCELL];
    bit     closed [NCELL];
    logic [1:0] pdir [NCELL];
    int     path_cells [NCELL];
    int     path_cnt;

    t_rsp   pending_rsps [$];
    int     errors;
    longint cycles;
    bit     no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    function automatic bit in_grid(int row, int col);
        return row >= 0 && col >= 0 && row <= mxy - mny && col <= mxx - mnx
            && row < GH && col < GW;
    endfunction

    function automatic int adist(int a, int b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic bit passable(int idx, bit chk);
        return !coll_map[idx] && (!chk || occ_map[idx] == 16'd0);
    endfunction

    function automatic int search_path(int sr, int sc, int dr, int dc, bit chk);
        logic [63:0] open_keys [$];
        logic [63:0] key;
        int          best, row, col, idx, nr, nc, nidx, n, r, c, pos;
        int unsigned f, g, nf;
        int          rstep [4];
        int          cstep [4];
        bit          found;
        rstep = '{1, -1, 0, 0};
        cstep = '{0, 0, -1, 1};
        found = 0;
        for (int k = 0; k < NCELL; k++) begin
            closed[k] = 0;
            open_f[k] = 32'hFFFF_FFFF;
        end
        idx = sr * GW + sc;
        open_f[idx] = 10 * (adist(sr, dr) + adist(sc, dc));
        open_keys.insert(open_keys.size(), {open_f[idx], sr[15:0], sc[15:0]});
        while (open_keys.size() > 0) begin
            best = 0;
            for (int k = 1; k < open_keys.size(); k++)
                if (open_keys[k] < open_keys[best]) best = k;
            key = open_keys[best];
            open_keys.delete(best);
            f = key[63:32];
            row = key[31:16];
            col = key[15:0];
            idx = row * GW + col;
            if (closed[idx]) continue;
            closed[idx] = 1;
            if (row == dr && col == dc) begin
                found = 1;
                break;
            end
            g = f - 10 * (adist(row, dr) + adist(col, dc));
            for (int d = 0; d < 4; d++) begin
                nr = row + rstep[d];
                nc = col + cstep[d];
                if (!in_grid(nr, nc)) continue;
                nidx = nr * GW + nc;
                if ((nr != dr || nc != dc) && !passable(nidx, chk)) continue;
                if (closed[nidx]) continue;
                nf = g + 10 + 10 * (adist(nr, dr) + adist(nc, dc));
                if (open_f[nidx] <= nf) continue;
                open_f[nidx] = nf;
                pdir[nidx] = d[1:0];
                open_keys.insert(open_keys.size(), {nf, nr[15:0], nc[15:0]});
            end
        end
        if (!found) return 0;
        n = 1;
        r = dr;
        c = dc;
        while ((r != sr || c != sc) && n <= NCELL) begin
            idx = pdir[r * GW + c];
            r -= rstep[idx];
            c -= cstep[idx];
            n++;
        end
        if (n > NCELL) n = NCELL;
        pos = n;
        r = dr;
        c = dc;
        while (pos > 0) begin
            pos--;
            path_cells[pos] = r * GW + c;
            if (r == sr && c == sc) break;
            idx = pdir[r * GW + c];
            r -= rstep[idx];
            c -= cstep[idx];
        end
        return n;
    endfunction

    function automatic t_rsp map_model_step(t_req q);
        t_rsp o;
        int   tr, tc, fr, fc, tidx, fidx, pcell, row, col;
        bit   tin, fin;
        o = '{default: '0};
        tc = int'($signed(q.tx)) - mnx;
        tr = mxy - int'($signed(q.ty));
        fc = int'($signed(q.fx)) - mnx;
        fr = mxy - int'($signed(q.fy));
        tin = in_grid(tr, tc);
        fin = in_grid(fr, fc);
        tidx = tin ? tr * GW + tc : 0;
        fidx = fin ? fr * GW + fc : 0;
        case (q.op)
            gmap_pkg::OP_LOAD: begin
                if (tin) begin
                    coll_map[tidx] = q.blk;
                    o.ok = 1;
                end
            end
            gmap_pkg::OP_CANGO: o.ok = tin && passable(tidx, q.chk);
            gmap_pkg::OP_FIND: begin
                if (tin) begin
                    o.occ = occ_map[tidx];
                    o.ok = 1;
                end
            end
            gmap_pkg::OP_MOVE: begin
                if (q.obj_id != 0 && tin && passable(tidx, 1'b1)) begin
                    if (fin && occ_map[fidx] == q.obj_id) occ_map[fidx] = 16'd0;
                    occ_map[tidx] = q.obj_id;
                    o.ok = 1;
                end
            end
            gmap_pkg::OP_LEAVE: begin
                if (q.obj_id != 0 && fin) begin
                    if (occ_map[fidx] == q.obj_id) occ_map[fidx] = 16'd0;
                    o.ok = 1;
                end
            end
            gmap_pkg::OP_PATH: begin
                path_cnt = (tin && fin) ? search_path(fr, fc, tr, tc, q.chk) : 0;
                o.ok = path_cnt != 0;
                o.plen = path_cnt[12:0];
            end
            gmap_pkg::OP_RDPATH: begin
                o.plen = path_cnt[12:0];
                if (int'(q.pidx) < path_cnt) begin
                    pcell = path_cells[q.pidx];
                    row = pcell / GW;
                    col = pcell % GW;
                    o.cx = 16'(col + mnx);
                    o.cy = 16'(mxy - row);
                    o.ok = 1;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic t_req make_req(logic [2:0] op, logic [15:0] obj, int fx, int fy,
                                      int tx, int ty, bit chk, bit blk, int pidx);
        t_req q;
        q.op = op;
        q.obj_id = obj;
        q.fx = 16'(fx);
        q.fy = 16'(fy);
        q.tx = 16'(tx);
        q.ty = 16'(ty);
        q.chk = chk;
        q.blk = blk;
        q.pidx = 12'(pidx);
        return q;
    endfunction

    task automatic send_item(t_req q);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 22) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.op = q.op;
        req_if.obj_id = q.obj_id;
        req_if.from_x = q.fx;
        req_if.from_y = q.fy;
        req_if.to_x = q.tx;
        req_if.to_y = q.ty;
        req_if.check_objects = q.chk;
        req_if.blocked = q.blk;
        req_if.path_index = q.pidx;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_rsps.insert(pending_rsps.size(), map_model_step(q));
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_rsps.size() > 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = 16'(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            gmap_pkg::CFG_MIN_X: mnx = int'($signed(16'(val)));
            gmap_pkg::CFG_MAX_X: mxx = int'($signed(16'(val)));
            gmap_pkg::CFG_MIN_Y: mny = int'($signed(16'(val)));
            default:             mxy = int'($signed(16'(val)));
        endcase
    endtask

    task automatic set_map(int x0, int x1, int y0, int y1);
        drain();
        write_cfg(gmap_pkg::CFG_MIN_X, x0);
        write_cfg(gmap_pkg::CFG_MAX_X, x1);
        write_cfg(gmap_pkg::CFG_MIN_Y, y0);
        write_cfg(gmap_pkg::CFG_MAX_Y, y1);
    endtask

    always @(negedge i_clk) begin
        rsp_if.ready <= no_idle || $urandom_range(99) >= 22;
    end

    always @(posedge i_clk) begin
        t_rsp w;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsps.size() == 0) begin
                report_mismatch("unexpected response transaction", 1, 0);
            end else begin
                w = pending_rsps.pop_front();
                if (rsp_if.ok !== w.ok) report_mismatch("ok", rsp_if.ok, w.ok);
                if (rsp_if.occupant !== w.occ)
                    report_mismatch("occupant", rsp_if.occupant, w.occ);
                if (rsp_if.path_length !== w.plen)
                    report_mismatch("path_length", rsp_if.path_length, w.plen);
                if (rsp_if.cell_x !== w.cx) report_mismatch("cell_x", rsp_if.cell_x, w.cx);
                if (rsp_if.cell_y !== w.cy) report_mismatch("cell_y", rsp_if.cell_y, w.cy);
            end
        end
    end

    task automatic test_table_ops();
        send_item(make_req(gmap_pkg::OP_LOAD, 0, 0, 0, 5, 5, 0, 1, 0));
        send_item(make_req(gmap_pkg::OP_CANGO, 0, 0, 0, 5, 5, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_LOAD, 0, 0, 0, 64, 5, 0, 1, 0));
        send_item(make_req(gmap_pkg::OP_MOVE, 16'hFFFF, 0, 0, 6, 5, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_CANGO, 0, 0, 0, 6, 5, 1, 0, 0));
        send_item(make_req(gmap_pkg::OP_CANGO, 0, 0, 0, 6, 5, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_MOVE, 16'h0, 0, 0, 7, 5, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_MOVE, 16'h1234, 6, 5, 5, 5, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_MOVE, 16'hFFFF, 6, 5, 7, 5, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_FIND, 0, 0, 0, 7, 5, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_FIND, 0, 0, 0, -1, 5, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_LEAVE, 16'h0001, 7, 5, 0, 0, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_LEAVE, 16'hFFFF, 7, 5, 0, 0, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_LEAVE, 16'hFFFF, 7, 64, 0, 0, 0, 0, 0));
        send_item(make_req(OP_UNUSED, 16'hFFFF, -1, -1, -1, -1, 1, 1, 4095));
    endtask

    task automatic test_path_cases();
        send_item(make_req(gmap_pkg::OP_PATH, 0, 3, 3, 3, 3, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_RDPATH, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_PATH, 0, 4, 5, 8, 5, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_RDPATH, 0, 0, 0, 0, 0, 0, 0, 2));
        send_item(make_req(gmap_pkg::OP_RDPATH, 0, 0, 0, 0, 0, 0, 0, 4095));
        send_item(make_req(gmap_pkg::OP_PATH, 0, 0, 0, 70, 0, 0, 0, 0));
        set_map(10, 13, 20, 23);
        send_item(make_req(gmap_pkg::OP_LOAD, 0, 0, 0, 11, 23, 0, 1, 0));
        send_item(make_req(gmap_pkg::OP_LOAD, 0, 0, 0, 11, 22, 0, 1, 0));
        send_item(make_req(gmap_pkg::OP_LOAD, 0, 0, 0, 11, 21, 0, 1, 0));
        send_item(make_req(gmap_pkg::OP_MOVE, 16'h0042, 0, 0, 11, 20, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_PATH, 0, 10, 23, 11, 20, 1, 0, 0));
        send_item(make_req(gmap_pkg::OP_PATH, 0, 10, 23, 13, 23, 1, 0, 0));
        send_item(make_req(gmap_pkg::OP_PATH, 0, 10, 23, 13, 23, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_RDPATH, 0, 0, 0, 0, 0, 0, 0, 3));
        drain();
        write_cfg(gmap_pkg::CFG_MIN_X, 100);
        send_item(make_req(gmap_pkg::OP_RDPATH, 0, 0, 0, 0, 0, 0, 0, 5));
    endtask

    task automatic test_config_extremes();
        set_map(-32768, 32767, -32768, 32767);
        send_item(make_req(gmap_pkg::OP_LOAD, 0, 0, 0, -32767, 32767, 0, 1, 0));
        send_item(make_req(gmap_pkg::OP_PATH, 0, -32768, 32767, -32766, 32767, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_RDPATH, 0, 0, 0, 0, 0, 0, 0, 2));
        send_item(make_req(gmap_pkg::OP_CANGO, 0, 0, 0, 32767, -32768, 0, 0, 0));
        set_map(32767, -32768, 32767, -32768);
        send_item(make_req(gmap_pkg::OP_LOAD, 0, 0, 0, 32767, 32767, 0, 1, 0));
        send_item(make_req(gmap_pkg::OP_PATH, 0, 32767, 32767, 32767, 32767, 0, 0, 0));
        send_item(make_req(gmap_pkg::OP_RDPATH, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    function automatic int pick_coord(int lo, int hi);
        if ($urandom_range(99) < 85) return $urandom_range(hi - lo + 2) + lo - 1;
        return int'($signed(16'($urandom)));
    endfunction

    task automatic test_random();
        int   x0, y0, sx, sy, r;
        t_req q;
        for (int ph = 0; ph < 4; ph++) begin
            sx = $urandom_range(4, 2);
            sy = $urandom_range(4, 2);
            case (ph)
                0: begin x0 = -32768; y0 = -32768; end
                1: begin x0 = 32767 - sx; y0 = 32767 - sy; end
                default: begin
                    x0 = $urandom_range(65000) - 32768;
                    y0 = $urandom_range(65000) - 32768;
                end
            endcase
            set_map(x0, x0 + sx, y0, y0 + sy);
            no_idle = (ph == 1);
            for (int n = 0; n < 120; n++) begin
                r = $urandom_range(99);
                q.op = r < 20 ? gmap_pkg::OP_LOAD : r < 32 ? gmap_pkg::OP_CANGO :
                       r < 44 ? gmap_pkg::OP_FIND : r < 62 ? gmap_pkg::OP_MOVE :
                       r < 72 ? gmap_pkg::OP_LEAVE : r < 77 ? gmap_pkg::OP_PATH :
                       r < 96 ? gmap_pkg::OP_RDPATH : OP_UNUSED;
                r = $urandom_range(99);
                q.obj_id = r < 70 ? 16'($urandom_range(5, 1)) : r < 80 ? 16'd0 : 16'($urandom);
                q.fx = 16'(pick_coord(x0, x0 + sx));
                q.fy = 16'(pick_coord(y0, y0 + sy));
                q.tx = 16'(pick_coord(x0, x0 + sx));
                q.ty = 16'(pick_coord(y0, y0 + sy));
                q.chk = $urandom_range(1);
                q.blk = $urandom_range(99) < 35;
                q.pidx = $urandom_range(99) < 80 ? 12'($urandom_range(path_cnt + 1))
                                                 : 12'($urandom);
                send_item(q);
                if (ph == 2 && n == 60) drain();
            end
        end
        no_idle = 0;
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        no_idle = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = gmap_pkg::CFG_MIN_X;
        i_cfg_data = 16'd0;
        req_if.valid = 1'b0;
        req_if.op = gmap_pkg::OP_LOAD;
        req_if.obj_id = '0;
        req_if.from_x = '0;
        req_if.from_y = '0;
        req_if.to_x = '0;
        req_if.to_y = '0;
        req_if.check_objects = 1'b0;
        req_if.blocked = 1'b0;
        req_if.path_index = '0;
        rsp_if.ready = 1'b0;
        mnx = 0;
        mxx = 63;
        mny = 0;
        mxy = 63;
        path_cnt = 0;
        for (int k = 0; k < NCELL; k++) begin
            coll_map[k] = 0;
            occ_map[k] = 16'd0;
            pdir[k] = 2'd0;
            path_cells[k] = 0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_table_ops();
        test_path_cases();
        test_config_extremes();
        test_random();
        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending_rsps.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
